/* rtl/fcpm_pkg.sv */
// shared types, widths, register indexes and reset values of the palette mapper
package fcpm_pkg;

   // field and word widths
   localparam int SAMPLE_W    = 16;
   localparam int CHAN_W      = 8;
   localparam int CHANNELS    = 4;
   localparam int COLOR_W     = CHAN_W * CHANNELS;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COLOR_W;

   // palette store: one entry per stop color register
   localparam int STOP_REGS   = 4;
   localparam int STOP_ADDR_W = $clog2(STOP_REGS);

   // parameter defaults
   localparam int TABLE_ENTRIES_DEFAULT = 256;
   localparam int MAX_STOPS_DEFAULT     = 4;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [COLOR_W-1:0]     color_type;

   // register indexes
   localparam csr_index_type REG_RANGE_LOW    = CSR_INDEX_W'(0);
   localparam csr_index_type REG_RANGE_HIGH   = CSR_INDEX_W'(1);
   localparam csr_index_type REG_STOP_COUNT   = CSR_INDEX_W'(2);
   localparam csr_index_type REG_STOP_COLOR_0 = CSR_INDEX_W'(3);
   localparam csr_index_type REG_STOP_COLOR_1 = CSR_INDEX_W'(4);
   localparam csr_index_type REG_STOP_COLOR_2 = CSR_INDEX_W'(5);
   localparam csr_index_type REG_STOP_COLOR_3 = CSR_INDEX_W'(6);

   // register reset values
   localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RESET  = SAMPLE_W'(0);
   localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RESET = SAMPLE_W'(255);
   localparam logic [COUNT_W-1:0]         STOP_COUNT_RESET = COUNT_W'(4);
   localparam color_type STOP_COLOR_0_RESET = 32'h0000_B4FF;
   localparam color_type STOP_COLOR_1_RESET = 32'h00DC_DCFF;
   localparam color_type STOP_COLOR_2_RESET = 32'hFFFF_00FF;
   localparam color_type STOP_COLOR_3_RESET = 32'hFF32_00FF;

   // how the table index of a sample is formed
   typedef enum logic [1:0] {
      IDX_DIVIDE,
      IDX_ZERO,
      IDX_FULL,
      IDX_MIDDLE
   } idx_kind_type;

   // color of a palette entry that was never written
   function automatic color_type stop_reset_color(input logic [STOP_ADDR_W-1:0] addr);
      color_type color;
      case (addr)
         2'd0:    color = STOP_COLOR_0_RESET;
         2'd1:    color = STOP_COLOR_1_RESET;
         2'd2:    color = STOP_COLOR_2_RESET;
         default: color = STOP_COLOR_3_RESET;
      endcase
      return color;
   endfunction

endpackage

/* rtl/fcpm_req_if.sv */
// sample channel: valid, ready and one signed sample
interface fcpm_req_if import fcpm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

/* rtl/fcpm_rsp_if.sv */
// color channel: valid, ready and one rgba color
interface fcpm_rsp_if import fcpm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   output ready);
endinterface

/* rtl/false_color_palette_mapper.sv */
// false color palette mapper: sample to rgba through range scaling and stop interpolation
//
// Each sample is scaled against range_low..range_high into a table index and turned into an
// RGBA color by linear interpolation between the enabled palette stops (grey ramp below two
// stops). The block is a pipeline of $clog2(TABLE_ENTRIES)+6 stages (14 at the default of 256
// entries) and takes one sample every cycle unless an output stall has filled every stage.
// The depth comes from the index division, which resolves one quotient bit per stage, the
// registered read of the two stop colors from the palette memory, the blend, and the final
// divide by the last table index, done in one stage as a multiply by its reciprocal. A stall
// on the output holds only the stages that are full, so bubbles are squeezed out and new
// samples are still taken while a color waits, until every stage is full. The four stop
// colors live in a small palette memory; per-entry valid bits give the reset colors, so
// there is no clearing pass.
// The user must write configuration only while the pipeline is empty; the block itself
// does not enforce this.
module false_color_palette_mapper import fcpm_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   parameter int MAX_STOPS     = MAX_STOPS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   fcpm_req_if.sink               req_ch,
   fcpm_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // index and pipeline geometry
   localparam int IDX_W      = $clog2(TABLE_ENTRIES);
   localparam int DVD_W      = SAMPLE_W + IDX_W;
   localparam int MIX_W      = CHAN_W + IDX_W;
   localparam int NUM_W      = IDX_W + COUNT_W;
   localparam int STOP_LIMIT = (MAX_STOPS < STOP_REGS) ? MAX_STOPS : STOP_REGS;
   localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W-1:0]   IDX_MID   = IDX_W'((TABLE_ENTRIES - 1) / 2);
   localparam logic [COUNT_W-1:0] STOP_SAT  = COUNT_W'(STOP_LIMIT);

   // reciprocal of the last index, exact for every blend value
   localparam int NRM_SHIFT = MIX_W + IDX_W;
   localparam int RCP_W     = MIX_W + 2;
   localparam int PROD_W    = MIX_W + RCP_W;
   localparam logic [RCP_W-1:0] NRM_RECIP = RCP_W'(((longint'(1) << NRM_SHIFT)
                                           + longint'(TABLE_ENTRIES - 2))
                                           / longint'(TABLE_ENTRIES - 1));

   localparam int ST_ENTRY = 0;
   localparam int ST_SCALE = 1;
   localparam int ST_DIV0  = 2;
   localparam int ST_IDX   = ST_DIV0 + IDX_W;
   localparam int ST_SEL   = ST_IDX + 1;
   localparam int ST_MIX   = ST_SEL + 1;
   localparam int ST_NRM   = ST_MIX + 1;
   localparam int NS       = ST_NRM + 1;

   // configuration registers
   logic signed [SAMPLE_W-1:0] range_low_ff;
   logic signed [SAMPLE_W-1:0] range_high_ff;
   logic [COUNT_W-1:0]         stop_count_ff;
   logic [STOP_REGS-1:0]       stop_vld_ff;
   color_type                  stop_mem [STOP_REGS];
   logic                       stop_wr;
   logic [STOP_ADDR_W-1:0]     stop_wr_addr;
   csr_index_type              stop_offset;

   // pipeline control
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] stage_load;

   // entry and scale stages
   logic signed [SAMPLE_W:0]   span_full;
   logic signed [SAMPLE_W:0]   diff_full;
   logic                       span_pos;
   logic [DVD_W-1:0]           divisor_ext;
   idx_kind_type               entry_kind_ff, entry_kind_in;
   logic [SAMPLE_W-1:0]        entry_diff_ff;
   idx_kind_type               scale_kind_ff;
   logic [DVD_W-1:0]           scale_dvd_ff, scale_dvd_in;

   // index division stages
   logic [DVD_W-1:0]   div_rem_ff  [IDX_W];
   logic [DVD_W-1:0]   div_rem_in  [IDX_W];
   logic [DVD_W-1:0]   div_rem_src [IDX_W];
   logic [IDX_W-1:0]   div_quo_ff  [IDX_W];
   logic [IDX_W-1:0]   div_quo_in  [IDX_W];
   logic [IDX_W-1:0]   div_quo_src [IDX_W];
   idx_kind_type       div_kind_ff [IDX_W];
   idx_kind_type       div_kind_src[IDX_W];

   // index, stop select and palette read
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [COUNT_W-1:0]     sel_nsat;
   logic [COUNT_W-1:0]     sel_nm1;
   logic [COUNT_W-1:0]     sel_kfix;
   logic [NUM_W-1:0]       sel_num;
   logic [NUM_W-1:0]       sel_rnum;
   logic [STOP_ADDR_W-1:0] sel_k_ff, sel_k_in, sel_k1;
   logic [IDX_W-1:0]       sel_r_ff, sel_r_in;
   logic [IDX_W-1:0]       sel_idx_ff;
   logic                   sel_grey_ff, sel_grey_in;
   color_type              rd_a_ff, rd_b_ff;
   logic                   rd_a_vld_ff, rd_b_vld_ff;

   // blend and normalize stages
   color_type          col_a, col_b;
   logic [MIX_W-1:0]   mix_ff [CHANNELS];
   logic [MIX_W-1:0]   mix_in [CHANNELS];
   logic [CHAN_W-1:0]  nrm_ff [CHANNELS];
   logic [CHAN_W-1:0]  nrm_in [CHANNELS];

   // register write decode
   always_comb begin
      stop_offset  = csr_index - REG_STOP_COLOR_0;
      stop_wr_addr = stop_offset[STOP_ADDR_W-1:0];
      stop_wr      = 1'b0;
      unique case (csr_index) inside
         REG_STOP_COLOR_0, REG_STOP_COLOR_1, REG_STOP_COLOR_2, REG_STOP_COLOR_3:
            stop_wr = csr_wr_en;
         default:
            stop_wr = 1'b0;
      endcase
   end

   // scalar configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
         stop_count_ff <= STOP_COUNT_RESET;
         stop_vld_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index) inside
            REG_RANGE_LOW:  range_low_ff  <= csr_wdata[SAMPLE_W-1:0];
            REG_RANGE_HIGH: range_high_ff <= csr_wdata[SAMPLE_W-1:0];
            REG_STOP_COUNT: stop_count_ff <= csr_wdata[COUNT_W-1:0];
            REG_STOP_COLOR_0, REG_STOP_COLOR_1, REG_STOP_COLOR_2, REG_STOP_COLOR_3:
               stop_vld_ff[stop_wr_addr] <= 1'b1;
            default: ;
         endcase
      end
   end

   // handshake: a stage loads when it or any later stage has room
   genvar s;
   generate
      for (s = 0; s < NS; s++) begin : g_load
         assign stage_load[s] = rsp_ch.ready || !(&vld_ff[NS-1:s]);
      end
   endgenerate

   always_comb begin
      vld_in[0] = req_ch.valid;
      for (int i = 1; i < NS; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (stage_load[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_ch.ready = stage_load[ST_ENTRY];
   assign rsp_ch.valid = vld_ff[NS-1];

   // entry: classify the sample against the range
   always_comb begin
      span_full   = {range_high_ff[SAMPLE_W-1], range_high_ff}
                  - {range_low_ff[SAMPLE_W-1], range_low_ff};
      diff_full   = {req_ch.sample_value[SAMPLE_W-1], req_ch.sample_value}
                  - {range_low_ff[SAMPLE_W-1], range_low_ff};
      span_pos    = !span_full[SAMPLE_W] && (span_full != '0);
      divisor_ext = DVD_W'(span_full[SAMPLE_W-1:0]);
      if (!span_pos) begin
         entry_kind_in = IDX_MIDDLE;
      end else if (req_ch.sample_value <= range_low_ff) begin
         entry_kind_in = IDX_ZERO;
      end else if (req_ch.sample_value >= range_high_ff) begin
         entry_kind_in = IDX_FULL;
      end else begin
         entry_kind_in = IDX_DIVIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[ST_ENTRY]) begin
         entry_kind_ff <= entry_kind_in;
         entry_diff_ff <= diff_full[SAMPLE_W-1:0];
      end
   end

   // scale: offset times the last table index
   assign scale_dvd_in = DVD_W'(entry_diff_ff) * DVD_W'(IDX_LAST);

   always_ff @(posedge clock) begin
      if (stage_load[ST_SCALE]) begin
         scale_kind_ff <= entry_kind_ff;
         scale_dvd_ff  <= scale_dvd_in;
      end
   end

   // index division: one quotient bit per stage, most significant first
   genvar j;
   generate
      for (j = 0; j < IDX_W; j++) begin : g_div
         localparam int B = IDX_W - 1 - j;
         logic [DVD_W-1:0] trial;

         if (j == 0) begin : g_first
            assign div_rem_src[j]  = scale_dvd_ff;
            assign div_quo_src[j]  = '0;
            assign div_kind_src[j] = scale_kind_ff;
         end else begin : g_next
            assign div_rem_src[j]  = div_rem_ff[j-1];
            assign div_quo_src[j]  = div_quo_ff[j-1];
            assign div_kind_src[j] = div_kind_ff[j-1];
         end

         always_comb begin
            trial = divisor_ext << B;
            if (div_rem_src[j] >= trial) begin
               div_rem_in[j] = div_rem_src[j] - trial;
               div_quo_in[j] = div_quo_src[j] | (IDX_W'(1) << B);
            end else begin
               div_rem_in[j] = div_rem_src[j];
               div_quo_in[j] = div_quo_src[j];
            end
         end

         always_ff @(posedge clock) begin
            if (stage_load[ST_DIV0+j]) begin
               div_rem_ff[j]  <= div_rem_in[j];
               div_quo_ff[j]  <= div_quo_in[j];
               div_kind_ff[j] <= div_kind_src[j];
            end
         end
      end
   endgenerate

   // table index from the quotient or the range corner cases
   always_comb begin
      case (div_kind_ff[IDX_W-1])
         IDX_DIVIDE: idx_in = div_quo_ff[IDX_W-1];
         IDX_ZERO:   idx_in = '0;
         IDX_FULL:   idx_in = IDX_LAST;
         default:    idx_in = IDX_MID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_load[ST_IDX]) begin
         idx_ff <= idx_in;
      end
   end

   // segment and fraction: k and r of idx*(n-1) over the last index
   always_comb begin
      sel_nsat = (stop_count_ff > STOP_SAT) ? STOP_SAT : stop_count_ff;
      sel_nm1  = sel_nsat - COUNT_W'(1);
      sel_num  = NUM_W'(idx_ff) * NUM_W'(sel_nm1);
      sel_k_in = '0;
      sel_rnum = sel_num;
      for (int i = 1; i < STOP_REGS; i++) begin
         if (sel_num >= NUM_W'(i * (TABLE_ENTRIES - 1))) begin
            sel_k_in = STOP_ADDR_W'(i);
            sel_rnum = sel_num - NUM_W'(i * (TABLE_ENTRIES - 1));
         end
      end
      sel_r_in = sel_rnum[IDX_W-1:0];
      sel_kfix = sel_nsat - COUNT_W'(2);
      // top of the last segment
      if (COUNT_W'(sel_k_in) >= sel_nm1) begin
         sel_k_in = sel_kfix[STOP_ADDR_W-1:0];
         sel_r_in = IDX_LAST;
      end
      sel_k1      = sel_k_in + STOP_ADDR_W'(1);
      sel_grey_in = (sel_nsat < COUNT_W'(2));
   end

   // palette memory: written by configuration, two registered reads per sample
   always_ff @(posedge clock) begin
      if (stop_wr) begin
         stop_mem[stop_wr_addr] <= csr_wdata[COLOR_W-1:0];
      end
      if (stage_load[ST_SEL]) begin
         rd_a_ff     <= stop_mem[sel_k_in];
         rd_b_ff     <= stop_mem[sel_k1];
         rd_a_vld_ff <= stop_vld_ff[sel_k_in];
         rd_b_vld_ff <= stop_vld_ff[sel_k1];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[ST_SEL]) begin
         sel_k_ff    <= sel_k_in;
         sel_r_ff    <= sel_r_in;
         sel_idx_ff  <= idx_ff;
         sel_grey_ff <= sel_grey_in;
      end
   end

   // blend: c_k*(M-r) + c_k+1*r per channel, grey ramp as a blend of 0 and full scale
   always_comb begin
      logic [CHAN_W-1:0] ca;
      logic [CHAN_W-1:0] cb;
      logic [IDX_W-1:0]  rr;
      col_a = rd_a_vld_ff ? rd_a_ff : stop_reset_color(sel_k_ff);
      col_b = rd_b_vld_ff ? rd_b_ff : stop_reset_color(sel_k_ff + STOP_ADDR_W'(1));
      for (int c = 0; c < CHANNELS; c++) begin
         ca = col_a[COLOR_W-1-CHAN_W*c -: CHAN_W];
         cb = col_b[COLOR_W-1-CHAN_W*c -: CHAN_W];
         rr = sel_r_ff;
         if (sel_grey_ff) begin
            ca = (c == CHANNELS - 1) ? '1 : '0;
            cb = '1;
            rr = sel_idx_ff;
         end
         mix_in[c] = MIX_W'(ca) * MIX_W'(IDX_LAST - rr) + MIX_W'(cb) * MIX_W'(rr);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[ST_MIX]) begin
         for (int c = 0; c < CHANNELS; c++) begin
            mix_ff[c] <= mix_in[c];
         end
      end
   end

   // normalize: divide each blend by the last index as a multiply by its reciprocal
   always_comb begin
      logic [PROD_W-1:0] prod;
      for (int c = 0; c < CHANNELS; c++) begin
         prod      = PROD_W'(mix_ff[c]) * PROD_W'(NRM_RECIP);
         nrm_in[c] = prod[NRM_SHIFT +: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[ST_NRM]) begin
         for (int c = 0; c < CHANNELS; c++) begin
            nrm_ff[c] <= nrm_in[c];
         end
      end
   end

   // output register is the normalize stage
   assign rsp_ch.red   = nrm_ff[0];
   assign rsp_ch.green = nrm_ff[1];
   assign rsp_ch.blue  = nrm_ff[2];
   assign rsp_ch.alpha = nrm_ff[3];

endmodule

/* rtl/fcpm_checker.sv */
// port-level checks of the palette mapper and their bind to the top level
module fcpm_checker import fcpm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_red,
   input logic [CHAN_W-1:0] rsp_green,
   input logic [CHAN_W-1:0] rsp_blue,
   input logic [CHAN_W-1:0] rsp_alpha
);

   // a stalled color stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("color transfer dropped while stalled");

   // a stalled color keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_red, rsp_green, rsp_blue, rsp_alpha}))
      else $error("color changed while stalled");

   // reset empties the pipeline and opens the input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // an output that drains lets the whole pipeline move
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

endmodule

bind false_color_palette_mapper fcpm_checker u_fcpm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_red   (rsp_ch.red),
   .rsp_green (rsp_ch.green),
   .rsp_blue  (rsp_ch.blue),
   .rsp_alpha (rsp_ch.alpha)
);

/* verif/false_color_palette_mapper_test.sv */
// self-checking testbench for the false color palette mapper: directed and random samples
`timescale 1ns / 100ps

module false_color_palette_mapper_test;
   import fcpm_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int LAST_INDEX   = TABLE_ENTRIES_DEFAULT - 1;
   localparam int GREY_FULL    = 255;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 108;
   localparam int CYCLE_LIMIT  = 200000;

   // index with no register behind it
   localparam csr_index_type REG_UNUSED = CSR_INDEX_W'(7);

   // idle profiles of sender and receiver
   localparam int IDLE_SEND_LIGHT = 0;
   localparam int IDLE_SEND_HEAVY = 1;
   localparam int IDLE_NONE       = 2;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      color_type                  color;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   fcpm_req_if req_ch ();
   fcpm_rsp_if rsp_ch ();

   false_color_palette_mapper u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadow used by the color predictor
   logic signed [SAMPLE_W-1:0] range_low_reg;
   logic signed [SAMPLE_W-1:0] range_high_reg;
   logic [COUNT_W-1:0]         stop_count_reg;
   color_type                  stop_colors[STOP_REGS];

   logic signed [SAMPLE_W-1:0] pending_samples[$];
   pixel_type                  expected_pixels[$];

   int   idle_mode = IDLE_SEND_LIGHT;
   logic hold_go   = 1'b0;
   logic rsp_hold;
   logic req_fire;
   int   error_count = 0;
   int   cycle_count = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // expected color of one sample under the current register settings
   function automatic color_type predict_color(input logic signed [SAMPLE_W-1:0] sample);
      int        span;
      int        index;
      int        stops;
      int        num;
      int        seg;
      int        frac;
      int        a;
      int        b;
      color_type color;
      span = int'(range_high_reg) - int'(range_low_reg);
      if (span <= 0) begin
         index = LAST_INDEX / 2;
      end else if (sample <= range_low_reg) begin
         index = 0;
      end else if (sample >= range_high_reg) begin
         index = LAST_INDEX;
      end else begin
         index = ((int'(sample) - int'(range_low_reg)) * LAST_INDEX) / span;
      end
      stops = int'(stop_count_reg);
      if (stops > MAX_STOPS_DEFAULT) stops = MAX_STOPS_DEFAULT;
      if (stops > STOP_REGS) stops = STOP_REGS;
      // grey ramp below two stops
      if (stops < 2) begin
         a = (index * GREY_FULL) / LAST_INDEX;
         color = {CHAN_W'(a), CHAN_W'(a), CHAN_W'(a), CHAN_W'(GREY_FULL)};
         return color;
      end
      num  = index * (stops - 1);
      seg  = num / LAST_INDEX;
      frac = num % LAST_INDEX;
      if (seg >= stops - 1) begin
         seg  = stops - 2;
         frac = LAST_INDEX;
      end
      for (int c = 0; c < CHANNELS; c++) begin
         a = int'(stop_colors[seg][COLOR_W-1-CHAN_W*c -: CHAN_W]);
         b = int'(stop_colors[seg+1][COLOR_W-1-CHAN_W*c -: CHAN_W]);
         color[COLOR_W-1-CHAN_W*c -: CHAN_W] =
            CHAN_W'((a * (LAST_INDEX - frac) + b * frac) / LAST_INDEX);
      end
      return color;
   endfunction

   function automatic int clamp_sample(input int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   function automatic logic sender_idle();
      case (idle_mode)
         IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 38;
         IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 52;
         default:         return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_idle();
      case (idle_mode)
         IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 52;
         IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 38;
         default:         return 1'b0;
      endcase
   endfunction

   // random sample, mostly inside the configured range and at its edges
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int span;
      int pick;
      int v;
      span = int'(range_high_reg) - int'(range_low_reg);
      pick = $urandom_range(0, 9);
      if (span > 0 && pick < 6) begin
         v = int'(range_low_reg) + int'($urandom_range(0, span));
      end else if (pick == 6) begin
         v = ($urandom_range(0, 1) ? int'(range_low_reg) : int'(range_high_reg))
             + int'($urandom_range(0, 2)) - 1;
         v = clamp_sample(v);
      end else begin
         v = int'($urandom);
      end
      return SAMPLE_W'(v);
   endfunction

   // register write, mirrored into the shadow
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         REG_RANGE_LOW:    range_low_reg  = data[SAMPLE_W-1:0];
         REG_RANGE_HIGH:   range_high_reg = data[SAMPLE_W-1:0];
         REG_STOP_COUNT:   stop_count_reg = data[COUNT_W-1:0];
         REG_STOP_COLOR_0: stop_colors[0] = data;
         REG_STOP_COLOR_1: stop_colors[1] = data;
         REG_STOP_COLOR_2: stop_colors[2] = data;
         REG_STOP_COLOR_3: stop_colors[3] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic write_range(input int low_value, input int high_value);
      write_reg(REG_RANGE_LOW, {16'($urandom), SAMPLE_W'(low_value)});
      write_reg(REG_RANGE_HIGH, {16'($urandom), SAMPLE_W'(high_value)});
   endtask

   // new random setting of every register
   task automatic random_config();
      int lo;
      int hi;
      int count;
      case ($urandom_range(0, 9))
         0: begin
            lo = -32768;
            hi = 32767;
         end
         1: begin
            // empty or inverted range
            lo = int'($urandom_range(0, 65535)) - 32768;
            hi = clamp_sample(lo - int'($urandom_range(0, 500)));
         end
         2: begin
            lo = int'($urandom_range(0, 65535)) - 32768;
            hi = clamp_sample(lo + int'($urandom_range(1, 3)));
         end
         default: begin
            lo = int'($urandom_range(0, 65535)) - 32768;
            hi = clamp_sample(lo + int'($urandom_range(1, 2000)));
         end
      endcase
      write_range(lo, hi);
      count = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 4) : $urandom_range(0, 7);
      write_reg(REG_STOP_COUNT, {29'($urandom), COUNT_W'(count)});
      write_reg(REG_STOP_COLOR_0, $urandom);
      write_reg(REG_STOP_COLOR_1, $urandom);
      write_reg(REG_STOP_COLOR_2, $urandom);
      write_reg(REG_STOP_COLOR_3, $urandom);
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
   endtask

   // wait until every sample is sent and every color has come back
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_ch.valid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_samples(input int values[$]);
      foreach (values[i]) pending_samples = {pending_samples, SAMPLE_W'(values[i])};
      wait_drained();
   endtask

   // driver: sample transfers and result backpressure, changed on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_ch.valid || req_fire) begin
            if (pending_samples.size() != 0 && !sender_idle()) begin
               req_ch.valid        <= 1'b1;
               req_ch.sample_value <= pending_samples.pop_front();
            end else begin
               req_ch.valid        <= 1'b0;
               req_ch.sample_value <= SAMPLE_W'($urandom);
            end
         end
         rsp_ch.ready <= !rsp_hold && !receiver_idle();
      end
   end

   // monitor: predict on each accepted sample, check each accepted color
   always @(posedge clock) begin
      pixel_type want;
      pixel_type seen;
      color_type got;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            seen.sample     = req_ch.sample_value;
            seen.color      = predict_color(req_ch.sample_value);
            expected_pixels = {expected_pixels, seen};
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.alpha};
            if (expected_pixels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected color, expected none, got rgba %08h", $time, got);
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want.color) begin
                  error_count++;
                  $display("%0t: sample %0d: expected rgba %08h, got rgba %08h",
                           $time, want.sample, want.color, got);
               end
            end
         end
      end
   end

   // long receiver stall, counted here while the sender keeps going
   initial begin
      rsp_hold = 1'b0;
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("false_color_palette_mapper_test: FAIL");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      req_ch.valid        = 1'b0;
      req_ch.sample_value = '0;
      rsp_ch.ready        = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      range_low_reg       = RANGE_LOW_RESET;
      range_high_reg      = RANGE_HIGH_RESET;
      stop_count_reg      = STOP_COUNT_RESET;
      for (int i = 0; i < STOP_REGS; i++) stop_colors[i] = stop_reset_color(STOP_ADDR_W'(i));
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset settings: sample extremes and range edges
      send_samples('{-32768, 32767, -1, 0, 1, 127, 128, 254, 255, 256});
      // stop count above the stop registers saturates
      write_reg(REG_STOP_COUNT, 32'h7);
      send_samples('{0, 200, 32767});
      // grey ramp with one and with no stops
      write_reg(REG_STOP_COUNT, 32'h1);
      send_samples('{0, 100, 255});
      write_reg(REG_STOP_COUNT, 32'h0);
      send_samples('{77});
      // inverted and empty range take the midpoint
      write_reg(REG_STOP_COUNT, 32'h2);
      write_range(100, -100);
      send_samples('{5, -32768});
      write_range(5, 5);
      send_samples('{5});
      // write to an index with no register is ignored
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      write_range(0, 255);
      send_samples('{40});

      // random phases under changing settings and idle profiles
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            write_range(-32768, 32767);
            write_reg(REG_STOP_COUNT, 32'h4);
            write_reg(REG_STOP_COLOR_0, 32'h0000_0000);
            write_reg(REG_STOP_COLOR_1, 32'hFFFF_FFFF);
            write_reg(REG_STOP_COLOR_2, 32'h0000_0000);
            write_reg(REG_STOP_COLOR_3, 32'hFFFF_FFFF);
         end else begin
            random_config();
         end
         idle_mode = (p < 4) ? IDLE_SEND_LIGHT : (p < 7) ? IDLE_SEND_HEAVY : IDLE_NONE;
         if (p == 8) hold_go = 1'b1;
         repeat (PHASE_ITEMS) pending_samples = {pending_samples, random_sample()};
         wait_drained();
      end

      if (error_count == 0) begin
         $display("false_color_palette_mapper_test: PASS");
      end else begin
         $display("false_color_palette_mapper_test: FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/fcpm_pkg.sv
rtl/fcpm_req_if.sv
rtl/fcpm_rsp_if.sv
rtl/false_color_palette_mapper.sv
rtl/fcpm_checker.sv
verif/false_color_palette_mapper_test.sv
